>>> src/sst_pkg.sv
package sst_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;
    localparam int KEY_PORT_W = 32;
    localparam int COUNT_W    = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_MEMBER = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_POP    = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic apply;
        logic ins;
        logic del;
        logic all;
    } sst_ctl_t;

endpackage

>>> src/sst_cell.sv
module sst_cell
    import sst_pkg::*;
#(
    parameter int KW  = 32,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  logic          cmp_en,
    input  logic [KW-1:0] cmp_key,
    input  logic [CW-1:0] held_count,
    input  sst_ctl_t      ctl,
    input  logic          left_lt,
    input  logic [KW-1:0] left_key,
    input  logic [KW-1:0] right_key,
    output logic [KW-1:0] key_q,
    output logic          lt_q,
    output logic          eq_q
);

    logic [KW-1:0] key_reg, key_next;
    logic          lt_reg, lt_next;
    logic          eq_reg, eq_next;
    logic          occupied;

    assign occupied = held_count > CW'(IDX);

    always_comb begin
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        key_next = key_reg;
        if (cmp_en) begin
            lt_next = occupied && (key_reg < cmp_key);
            eq_next = occupied && (key_reg == cmp_key);
        end
        if (ctl.apply) begin
            if (ctl.ins && !lt_reg) begin
                key_next = left_lt ? cmp_key : left_key;
            end else if (ctl.del && (ctl.all || !lt_reg)) begin
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        lt_reg  <= lt_next;
        eq_reg  <= eq_next;
    end

    assign key_q = key_reg;
    assign lt_q  = lt_reg;
    assign eq_q  = eq_reg;

endmodule

>>> src/sorted_set_table.sv
// Sorted set of distinct keys held in a row of CAPACITY cells in ascending order. Each input
// beat carries an operation (insert, member query, remove, pop smallest) and a key, and gives
// exactly one result beat with the found flag, the popped key, the count held afterwards and a
// status code. In the cycle the beat is accepted all cells compare their key with the incoming
// key in parallel; in the EXEC state, once the output is free, each cell keeps its key, takes
// the incoming key or loads its left or right neighbor's key to open or close a gap while the
// result is registered. A new beat is accepted only after the current result is registered; a
// result waiting on the output does not block the next accept. Keys are taken modulo 2^KW.
module sorted_set_table
    import sst_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op[1:0], key[33:2], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // found, popped_value, entry_count, status
);

    localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [1:0]            op_reg, op_next;
    logic [KW-1:0]         key_reg, key_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [KW-1:0]         cell_key [CAPACITY];
    logic [CAPACITY-1:0]   cell_lt;
    logic [CAPACITY-1:0]   cell_eq;
    logic [KW-1:0]         in_key;
    logic [KW-1:0]         cmp_key;
    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  found;
    logic                  full;
    logic                  empty;
    logic [1:0]            status;
    logic [KEY_PORT_W-1:0] popped;
    sst_ctl_t              ctl;

    assign in_key   = s_tdata[2 +: KW];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_EXEC) && out_free;
    assign cmp_key  = (state_reg == ST_IDLE) ? in_key : key_reg;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    always_comb begin
        found  = 1'b0;
        status = STATUS_OK;
        popped = '0;
        ctl    = '0;
        unique case (op_reg)
            OP_INSERT: begin
                found   = |cell_eq;
                ctl.ins = !found && !full;
                if (!found && full) begin
                    status = STATUS_FULL;
                end
            end
            OP_MEMBER: begin
                found = |cell_eq;
            end
            OP_REMOVE: begin
                found   = |cell_eq;
                ctl.del = found;
            end
            OP_POP: begin
                found   = !empty;
                ctl.del = !empty;
                ctl.all = 1'b1;
                if (empty) begin
                    status = STATUS_EMPTY;
                end else begin
                    popped = KEY_PORT_W'(cell_key[0]);
                end
            end
            default: begin
                found = 1'b0;
            end
        endcase
        ctl.apply = commit;
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic          left_lt;
            logic [KW-1:0] left_key;
            logic [KW-1:0] right_key;
            if (gi == 0) begin : g_first
                assign left_lt  = 1'b1;
                assign left_key = '0;
            end else begin : g_mid
                assign left_lt  = cell_lt[gi-1];
                assign left_key = cell_key[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_key = '0;
            end else begin : g_inner
                assign right_key = cell_key[gi+1];
            end
            sst_cell #(
                .KW  (KW),
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .aclk       (aclk),
                .cmp_en     (accept),
                .cmp_key    (cmp_key),
                .held_count (count_reg),
                .ctl        (ctl),
                .left_lt    (left_lt),
                .left_key   (left_key),
                .right_key  (right_key),
                .key_q      (cell_key[gi]),
                .lt_q       (cell_lt[gi]),
                .eq_q       (cell_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = s_tdata[1:0];
                    key_next   = in_key;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (commit) begin
                    if (ctl.ins) begin
                        count_next = count_reg + 1'b1;
                    end else if (ctl.del) begin
                        count_next = count_reg - 1'b1;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {status, COUNT_W'(count_next), popped, found};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("held count exceeds capacity");

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_EXEC) && !s_tready)
        else $error("accepted beat did not start execution");

    a_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !commit |=> $stable(count_reg))
        else $error("held count changed without a result");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && status == STATUS_FULL) |-> (!found && count_next == count_reg))
        else $error("dropped insert changed the table");

    a_ins_del_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> !(ctl.ins && ctl.del))
        else $error("insert and delete both requested");
`endif

endmodule

>>> bench/sorted_set_table_test.sv
module sorted_set_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 8;

    // One result beat, laid out exactly as m_tdata from the highest bit down.
    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic [31:0]        popped;
        logic               found;
    } set_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // op[1:0], key[33:2], zero pad
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // found, popped_value, entry_count, status

    logic [31:0] set_keys[CAPACITY];
    int          set_size = 0;

    set_result_t pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    sorted_set_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_set_table_test: FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Applies one operation to the sorted table and gives the result it must produce.
    function automatic set_result_t apply_set_op(logic [1:0] op, logic [31:0] key);
        set_result_t res;
        int          pos;
        res = '0;
        if (op == OP_POP) begin
            if (set_size == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.found  = 1'b1;
                res.popped = set_keys[0];
                for (int i = 0; i < set_size - 1; i++) set_keys[i] = set_keys[i + 1];
                set_size--;
            end
        end else begin
            pos = 0;
            while (pos < set_size && set_keys[pos] < key) pos++;
            res.found = (pos < set_size) && (set_keys[pos] == key);
            if (op == OP_INSERT && !res.found) begin
                if (set_size >= CAPACITY) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (int i = set_size; i > pos; i--) set_keys[i] = set_keys[i - 1];
                    set_keys[pos] = key;
                    set_size++;
                end
            end else if (op == OP_REMOVE && res.found) begin
                for (int i = pos; i < set_size - 1; i++) set_keys[i] = set_keys[i + 1];
                set_size--;
            end
        end
        res.count = set_size[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input set_result_t exp_res,
                                   input set_result_t got_res);
        error_count++;
        if (error_count <= 10) begin
            $display("%0t: %s: expected found=%0b popped=%h count=%0d status=%0d",
                     $realtime, what, exp_res.found, exp_res.popped, exp_res.count,
                     exp_res.status);
            $display("%0t: %s:   actual found=%0b popped=%h count=%0d status=%0d",
                     $realtime, what, got_res.found, got_res.popped, got_res.count,
                     got_res.status);
        end
    endtask

    always @(posedge aclk) begin
        set_result_t got_res;
        set_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            got_res = m_tdata;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", '0, got_res);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res !== exp_res) begin
                    report_mismatch("result field mismatch", exp_res, got_res);
                end
            end
        end
    end

    // Sends one beat and records its prediction once it is accepted.
    task automatic send_item(input logic [1:0] op, input logic [31:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - 34){1'b0}}, key, op};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(apply_set_op(op, key));
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_edge_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(OP_POP, 32'h1234_5678);
        send_item(OP_REMOVE, 32'd7);
        send_item(OP_MEMBER, 32'd7);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_INSERT, 32'hFFFF_FFFF);
        send_item(OP_INSERT, 32'h0000_0000);
        send_item(OP_MEMBER, 32'h0000_0000);
        send_item(OP_MEMBER, 32'hFFFF_FFFF);
        // Descending inserts land in the middle and push larger cells up.
        for (int i = 14; i >= 1; i--) send_item(OP_INSERT, 32'h1111_1111 * i);
        send_item(OP_INSERT, 32'h5555_5555);
        send_item(OP_INSERT, 32'h7777_7777);
        send_item(OP_REMOVE, 32'h7777_7777);
        send_item(OP_POP, 32'hFFFF_FFFF);
        send_item(OP_REMOVE, 32'hFFFF_FFFF);
        wait_for_results();
    endtask

    task automatic test_random_mix(input int send_pct, input int recv_pct, input int n_items);
        logic [31:0] key_pool[24];
        logic [1:0]  op;
        logic [31:0] key;
        int          op_bias;
        int          roll;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        op_bias = 2;
        foreach (key_pool[i]) key_pool[i] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            // Insert-heavy and drain-heavy stretches drive the table to full and to empty.
            if (n % 30 == 0) op_bias = $urandom_range(2);
            roll = $urandom_range(99);
            case (op_bias)
                0: begin
                    op = (roll < 60) ? OP_INSERT : (roll < 75) ? OP_MEMBER :
                         (roll < 90) ? OP_REMOVE : OP_POP;
                end
                1: begin
                    op = (roll < 15) ? OP_INSERT : (roll < 30) ? OP_MEMBER :
                         (roll < 65) ? OP_REMOVE : OP_POP;
                end
                default: begin
                    op = roll[1:0];
                end
            endcase
            roll = $urandom_range(99);
            if (roll < 30 && set_size > 0) begin
                key = set_keys[$urandom_range(set_size - 1)];
            end else if (roll < 80) begin
                key = key_pool[$urandom_range(23)];
            end else if (roll < 85) begin
                key = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
            end else if (roll < 90) begin
                key = 32'h1 << $urandom_range(31);
            end else begin
                key = $urandom;
            end
            send_item(op, key);
        end
        wait_for_results();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_cases();
        test_random_mix(0, 0, 400);
        test_random_mix(86, 0, 400);
        test_random_mix(0, 86, 400);
        test_random_mix(36, 36, 400);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) error_count++;
        if (error_count == 0) begin
            $display("sorted_set_table_test: PASS");
        end else begin
            $display("sorted_set_table_test: FAIL");
        end
        $finish;
    end

endmodule
